// ===== rtl/core/sactc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sactc_pkg: shared types and constants of the cache tag controller
// Address width, default geometry, configuration register indexes and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sactc_pkg;

    localparam int ADDR_W     = 32;
    localparam int DEF_SETS   = 256;
    localparam int DEF_WAYS   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int WAY_OUT_W  = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TAG_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

    localparam logic [5:0] RST_TAG_WIDTH   = 6'd24;
    localparam logic [3:0] RST_INDEX_WIDTH = 4'd8;
    localparam logic [3:0] RST_WAYS_IN_USE = 4'd8;

    typedef enum logic [2:0] {
        S_CLEAR  = 3'b001,
        S_IDLE   = 3'b010,
        S_LOOKUP = 3'b100
    } t_state;

    typedef struct packed {
        logic clear;
        logic capture;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/core/sactc_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sactc interfaces: request, response and configuration channels
// Each channel carries valid, ready and its payload.
// ----------------------------------------------------------------------------
interface sactc_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] address;
    modport source (output valid, output cmd, output address, input ready);
    modport sink   (input valid, input cmd, input address, output ready);
endinterface

interface sactc_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic        evicted;
    logic        writeback;
    logic [2:0]  way_used;
    logic [31:0] access_count;
    logic [31:0] read_count;
    logic [31:0] write_count;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] eviction_count;
    logic [31:0] writeback_count;
    modport source (output valid, output hit, output evicted, output writeback,
                    output way_used, output access_count, output read_count,
                    output write_count, output hit_count, output miss_count,
                    output eviction_count, output writeback_count, input ready);
    modport sink   (input valid, input hit, input evicted, input writeback,
                    input way_used, input access_count, input read_count,
                    input write_count, input hit_count, input miss_count,
                    input eviction_count, input writeback_count, output ready);
endinterface

interface sactc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/sactc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sactc_ctrl: sequencer of the tag controller
// Runs the clearing sweep after reset, then takes one request at a time
// through capture and lookup, holding the lookup while the result waits.
// ----------------------------------------------------------------------------
module sactc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  sactc_pkg::t_status i_status,
    output logic              o_req_ready,
    output sactc_pkg::t_cmd   o_cmd
);
    import sactc_pkg::*;

    t_state r_state, n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_req_ready   = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready   = 1'b1;
                o_cmd.capture = i_req_valid;
                if (i_req_valid) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    a_capture_to_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> r_state == S_LOOKUP)
        else $error("capture not followed by lookup");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.commit && (o_cmd.capture || o_cmd.clear)))
        else $error("commit overlaps another command");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOKUP && !i_status.out_free) |=> r_state == S_LOOKUP)
        else $error("lookup left while output busy");

endmodule

// ===== rtl/core/sactc_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sactc_dpath: tag store, lookup logic, counters and result register
// Each row of the store holds one set: valid, dirty and recent bits and the
// tag of every way. A row is read on capture and written back on commit.
// ----------------------------------------------------------------------------
module sactc_dpath #(
    parameter int SETS = sactc_pkg::DEF_SETS,
    parameter int WAYS = sactc_pkg::DEF_WAYS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sactc_pkg::t_cmd            i_cmd,
    output sactc_pkg::t_status         o_status,
    input  logic                       i_req_cmd,
    input  logic [sactc_pkg::ADDR_W-1:0] i_req_address,
    sactc_rsp_if.source                o_rsp,
    sactc_cfg_if.sink                  i_cfg
);
    import sactc_pkg::*;

    localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W = WAYS * (ADDR_W + 3);
    localparam int N_CNT = 7;
    localparam int C_ACC = 0, C_RD = 1, C_WR = 2, C_HIT = 3, C_MISS = 4;
    localparam int C_EVICT = 5, C_WB = 6;

    // Configuration registers; writes are to be made only while idle, which the block does not enforce.
    logic [5:0] r_tag_width;
    logic [3:0] r_index_width;
    logic [3:0] r_ways_in_use;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_width   <= RST_TAG_WIDTH;
            r_index_width <= RST_INDEX_WIDTH;
            r_ways_in_use <= RST_WAYS_IN_USE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_TAG_WIDTH:   r_tag_width   <= i_cfg.data[5:0];
                REG_INDEX_WIDTH: r_index_width <= i_cfg.data[3:0];
                REG_WAYS_IN_USE: r_ways_in_use <= i_cfg.data[3:0];
                default: begin
                end
            endcase
        end
    end

    // Address split. Shift amounts run up to 32 so the address is widened.
    logic [5:0]          tw;
    logic [6:0]          end_sum;
    logic [5:0]          end_pos;
    logic [5:0]          nidx;
    logic [2*ADDR_W-1:0] addr_wide;
    logic [ADDR_W-1:0]   tag_in;
    logic [2*ADDR_W-1:0] set_shift;
    logic [15:0]         set_mask;
    logic [14:0]         set_raw;
    logic [SW-1:0]       lo_mod [256];
    logic [SW-1:0]       hi_mod [128];
    logic [SW:0]         set_sum;
    logic [SW-1:0]       set_sel;

    // Constant tables for the set index modulo SETS, split at bit 8.
    for (genvar gi = 0; gi < 256; gi++) begin : g_lo_mod
        assign lo_mod[gi] = SW'(gi % SETS);
    end
    for (genvar gh = 0; gh < 128; gh++) begin : g_hi_mod
        assign hi_mod[gh] = SW'((gh * 256) % SETS);
    end

    always_comb begin
        tw        = (r_tag_width > 6'd32) ? 6'd32 : r_tag_width;
        end_sum   = {1'b0, tw} + {3'b0, r_index_width};
        end_pos   = (end_sum > 7'd32) ? 6'd32 : end_sum[5:0];
        nidx      = end_pos - tw;
        addr_wide = {{ADDR_W{1'b0}}, i_req_address};
        tag_in    = ADDR_W'(addr_wide >> (6'd32 - tw));
        set_shift = addr_wide >> (6'd32 - end_pos);
        set_mask  = 16'((17'd1 << nidx[3:0]) - 17'd1);
        set_raw   = set_shift[14:0] & set_mask[14:0];
        set_sum   = {1'b0, hi_mod[set_raw[14:8]]} + {1'b0, lo_mod[set_raw[7:0]]};
        if (set_sum >= (SW+1)'(SETS)) begin
            set_sum = set_sum - (SW+1)'(SETS);
        end
        set_sel = set_sum[SW-1:0];
    end

    // Tag store and captured request.
    logic [ROW_W-1:0]  r_mem [SETS];
    logic [ROW_W-1:0]  r_row;
    logic [ADDR_W-1:0] r_tag;
    logic              r_write;
    logic [SW-1:0]     r_set;
    logic [SW-1:0]     r_clr_addr;
    logic              mem_we;
    logic [SW-1:0]     mem_waddr;
    logic [ROW_W-1:0]  mem_wdata;
    logic [ROW_W-1:0]  row_next;

    assign o_status.clear_last = (r_clr_addr == SW'(SETS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + SW'(1);
        end
    end

    assign mem_we    = i_cmd.clear || i_cmd.commit;
    assign mem_waddr = i_cmd.clear ? r_clr_addr : r_set;
    assign mem_wdata = i_cmd.clear ? '0 : row_next;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.capture) begin
            r_row   <= r_mem[set_sel];
            r_tag   <= tag_in;
            r_write <= i_req_cmd;
            r_set   <= set_sel;
        end
    end

    // Lookup on the captured row.
    logic [WAYS-1:0][ADDR_W-1:0] row_tag;
    logic [WAYS-1:0]             row_valid;
    logic [WAYS-1:0]             row_dirty;
    logic [WAYS-1:0]             row_recent;
    logic [4:0]                  ways;
    logic [WAYS-1:0]             act;
    logic                        placed;
    logic                        found;
    logic                        hit;
    logic                        evicted;
    logic                        wb;
    logic [WW-1:0]               way;
    logic [WW-1:0]               victim;
    logic [WAYS-1:0][ADDR_W-1:0] tag_next;
    logic [WAYS-1:0]             valid_next;
    logic [WAYS-1:0]             dirty_next;
    logic [WAYS-1:0]             recent_next;
    logic [4:0]                  way_ext;

    assign row_tag    = r_row[WAYS*ADDR_W-1:0];
    assign row_valid  = r_row[WAYS*ADDR_W +: WAYS];
    assign row_dirty  = r_row[WAYS*ADDR_W + WAYS +: WAYS];
    assign row_recent = r_row[WAYS*ADDR_W + 2*WAYS +: WAYS];

    always_comb begin
        if (r_ways_in_use == 4'd0) begin
            ways = 5'd1;
        end else if ({1'b0, r_ways_in_use} > 5'(WAYS)) begin
            ways = 5'(WAYS);
        end else begin
            ways = {1'b0, r_ways_in_use};
        end
        placed = 1'b0;
        hit    = 1'b0;
        way    = '0;
        found  = 1'b0;
        victim = '0;
        for (int w = 0; w < WAYS; w++) begin
            act[w] = 5'(w) < ways;
            if (!placed && act[w] && (!row_valid[w] || row_tag[w] == r_tag)) begin
                placed = 1'b1;
                hit    = row_valid[w];
                way    = WW'(w);
            end
            if (!found && act[w] && !row_recent[w]) begin
                found  = 1'b1;
                victim = WW'(w);
            end
        end
        recent_next = row_recent;
        if (!placed) begin
            // With every recent bit set, the set starts a new round at way 0.
            if (found) begin
                way = victim;
            end else begin
                way         = '0;
                recent_next = row_recent & ~act;
            end
        end
        evicted    = !placed;
        wb         = evicted && row_dirty[way];
        tag_next   = row_tag;
        valid_next = row_valid;
        dirty_next = row_dirty;
        if (hit) begin
            dirty_next[way] = row_dirty[way] | r_write;
        end else begin
            tag_next[way]   = r_tag;
            valid_next[way] = 1'b1;
            dirty_next[way] = r_write;
        end
        recent_next[way] = 1'b1;
        row_next = {recent_next, dirty_next, valid_next, tag_next};
        way_ext  = 5'(way);
    end

    // Statistics counters and result register.
    logic [ADDR_W-1:0] r_cnt [N_CNT];
    logic [ADDR_W-1:0] cnt_next [N_CNT];
    logic              r_out_valid;
    logic              r_hit;
    logic              r_evicted;
    logic              r_wb;
    logic [WAY_OUT_W-1:0] r_way;

    always_comb begin
        for (int k = 0; k < N_CNT; k++) begin
            cnt_next[k] = r_cnt[k];
        end
        cnt_next[C_ACC]   = r_cnt[C_ACC] + ADDR_W'(1);
        cnt_next[C_RD]    = r_cnt[C_RD] + ADDR_W'(!r_write);
        cnt_next[C_WR]    = r_cnt[C_WR] + ADDR_W'(r_write);
        cnt_next[C_HIT]   = r_cnt[C_HIT] + ADDR_W'(hit);
        cnt_next[C_MISS]  = r_cnt[C_MISS] + ADDR_W'(!hit);
        cnt_next[C_EVICT] = r_cnt[C_EVICT] + ADDR_W'(evicted);
        cnt_next[C_WB]    = r_cnt[C_WB] + ADDR_W'(wb);
    end

    assign o_status.out_free = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int k = 0; k < N_CNT; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                for (int k = 0; k < N_CNT; k++) begin
                    r_cnt[k] <= cnt_next[k];
                end
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_hit     <= hit;
            r_evicted <= evicted;
            r_wb      <= wb;
            r_way     <= way_ext[WAY_OUT_W-1:0];
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.hit             = r_hit;
    assign o_rsp.evicted         = r_evicted;
    assign o_rsp.writeback       = r_wb;
    assign o_rsp.way_used        = r_way;
    assign o_rsp.access_count    = r_cnt[C_ACC];
    assign o_rsp.read_count      = r_cnt[C_RD];
    assign o_rsp.write_count     = r_cnt[C_WR];
    assign o_rsp.hit_count       = r_cnt[C_HIT];
    assign o_rsp.miss_count      = r_cnt[C_MISS];
    assign o_rsp.eviction_count  = r_cnt[C_EVICT];
    assign o_rsp.writeback_count = r_cnt[C_WB];

    a_commit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || o_rsp.ready))
        else $error("result overwritten before it was taken");
    a_hit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_hit && r_evicted))
        else $error("hit and eviction reported together");
    a_wb_needs_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_wb || r_evicted))
        else $error("writeback without eviction");
    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_cnt[C_HIT] + r_cnt[C_MISS] == r_cnt[C_ACC]))
        else $error("hit and miss counts disagree with access count");

endmodule

// ===== rtl/core/set_assoc_cache_tag_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller: tag store of a write-back cache
// Looks up each request in a set-associative tag store and reports hit,
// eviction, writeback, the way used and seven wrapping statistics counters.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries a request (cmd: 0 read, 1 write; 32-bit address). o_rsp
//   returns one result per request. i_cfg writes tag_width (index 0),
//   index_width (1) and ways_in_use (2); it is always ready. Writes must be
//   made only while no request is in flight; the block does not enforce it.
//   A request is taken in the idle cycle, its set row is read from the tag
//   memory into a register at that edge, and in the lookup state, once the
//   output register is free, lookup and row update run and the result register loads.
//   One request is handled at a time: no new request is taken before the
//   result of the last one has been loaded into the result register.
//   While a result waits in the output register, the next request is still
//   accepted; its lookup holds until the waiting result is taken.
//   After reset a clearing pass writes SETS rows, one row per cycle, and no
//   request is accepted during it. Counters reset to zero.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_controller #(
    parameter int SETS = sactc_pkg::DEF_SETS,
    parameter int WAYS = sactc_pkg::DEF_WAYS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sactc_req_if.sink   i_req,
    sactc_rsp_if.source o_rsp,
    sactc_cfg_if.sink   i_cfg
);
    import sactc_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_req_ready;

    assign i_req.ready = w_req_ready;

    sactc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_status    (w_status),
        .o_req_ready (w_req_ready),
        .o_cmd       (w_cmd)
    );

    sactc_dpath #(
        .SETS (SETS),
        .WAYS (WAYS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_req_cmd     (i_req.cmd),
        .i_req_address (i_req.address),
        .o_rsp         (o_rsp),
        .i_cfg         (i_cfg)
    );

endmodule
